FILE: sv/chained_hash_index_defines.svh
// Assertion macros shared by the RTL.
`ifndef CHAINED_HASH_INDEX_DEFINES_SVH
`define CHAINED_HASH_INDEX_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CHI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CHI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/chi_pkg.sv
package chi_pkg;

   localparam int KEY_W      = 64;
   localparam int NUM_KEYS   = 4;
   localparam int ROW_W      = 10;
   localparam int BKT_W      = 11;
   localparam int LINK_W     = ROW_W + 1;
   localparam int KADDR_W    = ROW_W + 2;
   localparam int CNT_W      = ROW_W + 1;
   localparam logic [CNT_W-1:0] MAX_ROWS = CNT_W'(1024);
   localparam logic [3:0] BITS_MIN = 4'd4;
   localparam logic [3:0] BITS_MAX = 4'd11;

   localparam logic [63:0] FNV_BASIS   = 64'd14695981039346656037;
   localparam logic [8:0]  FNV_PRIME_LO = 9'd435;
   localparam int          FNV_PRIME_SH = 40;

   localparam logic [1:0] CSR_KEY_COUNT   = 2'd0;
   localparam logic [1:0] CSR_BUCKET_BITS = 2'd1;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_PROBE  = 2'd1,
      REQ_NEXT   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_KEY_WR,
      S_WALK,
      S_CMP,
      S_SUCC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       start;
      logic [1:0] kc_m1;
   } hash_ctl_type;

endpackage

FILE: sv/chi_channels.sv
interface chi_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic signed [chi_pkg::KEY_W-1:0] key_0;
   logic signed [chi_pkg::KEY_W-1:0] key_1;
   logic signed [chi_pkg::KEY_W-1:0] key_2;
   logic signed [chi_pkg::KEY_W-1:0] key_3;
   logic [chi_pkg::ROW_W-1:0]       row_index;
   modport source (output valid, req_type, key_0, key_1, key_2, key_3, row_index,
                   input ready);
   modport sink (input valid, req_type, key_0, key_1, key_2, key_3, row_index,
                 output ready);
endinterface

interface chi_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [chi_pkg::ROW_W-1:0] row_out;
   logic [chi_pkg::BKT_W-1:0] bucket_out;
   modport source (output valid, status, row_out, bucket_out, input ready);
   modport sink (input valid, status, row_out, bucket_out, output ready);
endinterface

interface chi_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [3:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/chi_ram.sv
module chi_ram #(
   parameter int AW = 10,
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/chi_hash.sv
module chi_hash (
   input  logic                                            clock,
   input  logic                                            reset,
   input  chi_pkg::hash_ctl_type                           ctl,
   input  logic [chi_pkg::NUM_KEYS-1:0][chi_pkg::KEY_W-1:0] keys,
   output logic                                            done,
   output logic [63:0]                                     hash
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  kc_ff, kc_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] word;
   logic [7:0]  byte_sel;
   logic [63:0] hx;

   always_comb begin
      word     = keys[cnt_ff[4:3]] >> {cnt_ff[2:0], 3'b000};
      byte_sel = word[7:0];
      hx       = h_ff ^ {56'd0, byte_sel};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      kc_in    = kc_ff;
      h_in     = h_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         kc_in   = ctl.kc_m1;
         h_in    = chi_pkg::FNV_BASIS;
      end else if (busy_ff) begin
         h_in   = (hx << chi_pkg::FNV_PRIME_SH) + hx * {55'd0, chi_pkg::FNV_PRIME_LO};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == {kc_ff, 3'b111}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      kc_ff  <= kc_in;
      h_ff   <= h_in;
   end

   assign done = done_ff;
   assign hash = h_ff;

endmodule

FILE: sv/chained_hash_index.sv
// Insert: hash the keys in use (K = keys in use), read the bucket head, link the new row, write its key words.
// Probe: hash, read the bucket head, then compare up to K keys per chain row visited; successor: one link read.
// Clear: one head-memory write per bucket, then the result beat.
// One request at a time; the result register frees the input while a beat waits.
// Reset is synchronous, active high; after reset a sweep clears all 2048 bucket heads
// before the first request is taken (configuration writes are taken throughout).
`include "chained_hash_index_defines.svh"

module chained_hash_index (
   input  logic clock,
   input  logic reset,
   chi_req_if.sink   req_ch,
   chi_rsp_if.source rsp_ch,
   chi_csr_if.sink   csr_ch
);

   localparam int RW = chi_pkg::ROW_W;
   localparam int BW = chi_pkg::BKT_W;
   localparam int LW = chi_pkg::LINK_W;

   chi_pkg::state_type    state_ff, state_in;
   chi_pkg::req_kind_type kind_ff, kind_in;
   chi_pkg::status_type   st_ff, st_in;
   logic [BW-1:0]         sweep_ff, sweep_in;
   logic                  sweep_rsp_ff, sweep_rsp_in;
   logic [chi_pkg::NUM_KEYS-1:0][chi_pkg::KEY_W-1:0] keys_ff, keys_in;
   logic [RW-1:0]         rix_ff, rix_in;
   logic [1:0]            kc_m1_ff, kc_m1_in;
   logic [chi_pkg::CNT_W-1:0] count_ff, count_in;
   logic [BW-1:0]         bucket_ff, bucket_in;
   logic [RW-1:0]         cur_ff, cur_in;
   logic                  have_ff, have_in;
   logic [1:0]            k_ff, k_in;
   logic [RW-1:0]         row_ff, row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [RW-1:0]         rsp_row_ff, rsp_row_in;
   logic [BW-1:0]         rsp_bucket_ff, rsp_bucket_in;
   logic [2:0]            key_count_ff, key_count_in;
   logic [3:0]            bucket_bits_ff, bucket_bits_in;

   logic                  accept;
   logic [1:0]            kc_m1_cur;
   logic [3:0]            bits_cl;
   logic [BW-1:0]         mask;
   logic [BW-1:0]         bucket_calc;
   chi_pkg::hash_ctl_type hctl;
   logic                  hdone;
   logic [63:0]           hval;

   logic                  head_we, head_re;
   logic [BW-1:0]         head_waddr, head_raddr;
   logic [LW-1:0]         head_wdata, head_rdata;
   logic                  next_we, next_re;
   logic [RW-1:0]         next_waddr, next_raddr;
   logic [LW-1:0]         next_wdata, next_rdata;
   logic                  key_we, key_re;
   logic [chi_pkg::KADDR_W-1:0] key_waddr, key_raddr;
   logic [chi_pkg::KEY_W-1:0]   key_wdata, key_rdata;

   chi_hash u_hash (
      .clock(clock), .reset(reset), .ctl(hctl), .keys(keys_ff), .done(hdone), .hash(hval)
   );

   chi_ram #(.AW(BW), .DW(LW)) u_head (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
   );

   chi_ram #(.AW(RW), .DW(LW)) u_next (
      .clock(clock), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
      .re(next_re), .raddr(next_raddr), .rdata(next_rdata)
   );

   chi_ram #(.AW(chi_pkg::KADDR_W), .DW(chi_pkg::KEY_W)) u_keys (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
      .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
   );

   assign req_ch.ready = (state_ff == chi_pkg::S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.row_out    = rsp_row_ff;
   assign rsp_ch.bucket_out = rsp_bucket_ff;

   always_comb begin
      if (key_count_ff == 3'd0) begin
         kc_m1_cur = 2'd0;
      end else if (key_count_ff > 3'd4) begin
         kc_m1_cur = 2'd3;
      end else begin
         kc_m1_cur = 2'(key_count_ff - 3'd1);
      end
      if (bucket_bits_ff < chi_pkg::BITS_MIN) begin
         bits_cl = chi_pkg::BITS_MIN;
      end else if (bucket_bits_ff > chi_pkg::BITS_MAX) begin
         bits_cl = chi_pkg::BITS_MAX;
      end else begin
         bits_cl = bucket_bits_ff;
      end
      mask        = {BW{1'b1}} >> (chi_pkg::BITS_MAX - bits_cl);
      bucket_calc = hval[BW-1:0] & mask;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      st_in         = st_ff;
      sweep_in      = sweep_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      keys_in       = keys_ff;
      rix_in        = rix_ff;
      kc_m1_in      = kc_m1_ff;
      count_in      = count_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      have_in       = have_ff;
      k_in          = k_ff;
      row_in        = row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_bucket_in = rsp_bucket_ff;
      hctl          = '0;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = {1'b1, count_ff[RW-1:0]};
      head_re       = 1'b0;
      head_raddr    = bucket_calc;
      next_we       = 1'b0;
      next_waddr    = count_ff[RW-1:0];
      next_wdata    = head_rdata;
      next_re       = 1'b0;
      next_raddr    = cur_ff;
      key_we        = 1'b0;
      key_waddr     = {count_ff[RW-1:0], k_ff};
      key_wdata     = keys_ff[k_ff];
      key_re        = 1'b0;
      key_raddr     = {cur_ff, 2'd0};

      case (state_ff)
         chi_pkg::S_SWEEP: begin
            head_we    = 1'b1;
            head_waddr = sweep_ff;
            head_wdata = '0;
            sweep_in   = sweep_ff + BW'(1);
            if (sweep_ff == {BW{1'b1}}) begin
               state_in = sweep_rsp_ff ? chi_pkg::S_RESP : chi_pkg::S_IDLE;
            end
         end
         chi_pkg::S_IDLE: begin
            if (accept) begin
               kind_in   = chi_pkg::req_kind_type'(req_ch.req_type);
               keys_in   = {req_ch.key_3, req_ch.key_2, req_ch.key_1, req_ch.key_0};
               rix_in    = req_ch.row_index;
               kc_m1_in  = kc_m1_cur;
               st_in     = chi_pkg::ST_OK;
               row_in    = '0;
               bucket_in = '0;
               k_in      = '0;
               case (chi_pkg::req_kind_type'(req_ch.req_type))
                  chi_pkg::REQ_INSERT, chi_pkg::REQ_PROBE: begin
                     hctl.start = 1'b1;
                     hctl.kc_m1 = kc_m1_cur;
                     state_in   = chi_pkg::S_HASH;
                  end
                  chi_pkg::REQ_NEXT: begin
                     if ({1'b0, req_ch.row_index} >= count_ff) begin
                        st_in    = chi_pkg::ST_RANGE;
                        state_in = chi_pkg::S_RESP;
                     end else begin
                        next_re    = 1'b1;
                        next_raddr = req_ch.row_index;
                        state_in   = chi_pkg::S_SUCC;
                     end
                  end
                  default: begin
                     count_in     = '0;
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = chi_pkg::S_SWEEP;
                  end
               endcase
            end
         end
         chi_pkg::S_HASH: begin
            if (hdone) begin
               bucket_in = bucket_calc;
               if (kind_ff == chi_pkg::REQ_INSERT && count_ff == chi_pkg::MAX_ROWS) begin
                  st_in    = chi_pkg::ST_FULL;
                  state_in = chi_pkg::S_RESP;
               end else begin
                  head_re  = 1'b1;
                  state_in = chi_pkg::S_HEAD;
               end
            end
         end
         chi_pkg::S_HEAD: begin
            if (kind_ff == chi_pkg::REQ_INSERT) begin
               next_we  = 1'b1;
               head_we  = 1'b1;
               row_in   = count_ff[RW-1:0];
               k_in     = '0;
               state_in = chi_pkg::S_KEY_WR;
            end else begin
               have_in  = head_rdata[LW-1];
               cur_in   = head_rdata[RW-1:0];
               state_in = chi_pkg::S_WALK;
            end
         end
         chi_pkg::S_KEY_WR: begin
            key_we = 1'b1;
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               count_in = count_ff + chi_pkg::CNT_W'(1);
               state_in = chi_pkg::S_RESP;
            end
         end
         chi_pkg::S_WALK: begin
            if (!have_ff || {1'b0, cur_ff} >= count_ff) begin
               st_in    = chi_pkg::ST_MISS;
               state_in = chi_pkg::S_RESP;
            end else begin
               key_re   = 1'b1;
               next_re  = 1'b1;
               k_in     = '0;
               state_in = chi_pkg::S_CMP;
            end
         end
         chi_pkg::S_CMP: begin
            if (key_rdata != keys_ff[k_ff]) begin
               have_in  = next_rdata[LW-1];
               cur_in   = next_rdata[RW-1:0];
               state_in = chi_pkg::S_WALK;
            end else if (k_ff == kc_m1_ff) begin
               row_in   = cur_ff;
               state_in = chi_pkg::S_RESP;
            end else begin
               key_re    = 1'b1;
               key_raddr = {cur_ff, k_ff + 2'd1};
               k_in      = k_ff + 2'd1;
            end
         end
         chi_pkg::S_SUCC: begin
            if (next_rdata[LW-1]) begin
               row_in = next_rdata[RW-1:0];
            end else begin
               st_in = chi_pkg::ST_MISS;
            end
            state_in = chi_pkg::S_RESP;
         end
         chi_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_row_in    = row_ff;
               rsp_bucket_in = bucket_ff;
               sweep_rsp_in  = 1'b0;
               state_in      = chi_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = chi_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      key_count_in   = key_count_ff;
      bucket_bits_in = bucket_bits_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            chi_pkg::CSR_KEY_COUNT:   key_count_in   = csr_ch.data[2:0];
            chi_pkg::CSR_BUCKET_BITS: bucket_bits_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= chi_pkg::S_SWEEP;
         sweep_ff       <= '0;
         sweep_rsp_ff   <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         key_count_ff   <= 3'd1;
         bucket_bits_ff <= chi_pkg::BITS_MAX;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         sweep_rsp_ff   <= sweep_rsp_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         key_count_ff   <= key_count_in;
         bucket_bits_ff <= bucket_bits_in;
      end
      kind_ff       <= kind_in;
      st_ff         <= st_in;
      keys_ff       <= keys_in;
      rix_ff        <= rix_in;
      kc_m1_ff      <= kc_m1_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      have_ff       <= have_in;
      k_ff          <= k_in;
      row_ff        <= row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   `CHI_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= chi_pkg::MAX_ROWS, "row count above capacity")
   `CHI_ASSERT_NEXT(a_one_at_a_time, accept, !req_ch.ready, "second beat taken while busy")
   `CHI_ASSERT_NEXT(a_insert_count, state_ff == chi_pkg::S_KEY_WR && k_ff == 2'd3, count_ff == $past(count_ff) + chi_pkg::CNT_W'(1), "insert did not advance row count")
   `CHI_ASSERT_NOW(a_succ_range, state_ff == chi_pkg::S_SUCC, {1'b0, rix_ff} < count_ff, "successor read past row count")

endmodule
